// ===== rtl/rtcn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTC nibble register clock: shared package
// Word layout, operation codes and configuration constants used across the
// clock unit.
// ----------------------------------------------------------------------------
package rtcn_pkg;

  // Operation carried by an input word
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } rtcn_op_e;

  // One input word as held in the input register
  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  reg_address;
    logic [3:0]  write_nibble;
    logic [15:0] elapsed_cycles;
  } rtcn_item_t;

  // Configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-1:0] CFG_ADDR_SEC_RATE = 3'd0;
  localparam logic [31:0] SEC_RATE_RESET = 32'd7159090;

  // Battery-backed nibble RAM
  localparam int unsigned RAM_NIBBLES = 26;
  localparam int unsigned RAM_BANK    = RAM_NIBBLES / 2;
  localparam int unsigned RAM_IDX_W   = $clog2(RAM_NIBBLES);

  // Read words carry the nibble in the low half over this mark
  localparam logic [3:0] READ_MARK = 4'hF;

endpackage : rtcn_pkg
`default_nettype wire

// ===== rtl/rtcn_apb_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTC configuration registers
// APB-style slave holding the prescaler rate (half-cycles per second).
// ----------------------------------------------------------------------------
module rtcn_apb_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rtcn_pkg::PADDR_W-1:0] paddr,
  input  wire logic [rtcn_pkg::PDATA_W-1:0] pwdata,
  output logic      [rtcn_pkg::PDATA_W-1:0] prdata,
  output logic                              pready,
  output logic      [31:0]                  sec_rate
);
  import rtcn_pkg::*;

  logic wr_en;

  // Write on the access phase; the slave never inserts wait states
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sec_rate <= SEC_RATE_RESET;
    end else if (wr_en && (paddr == CFG_ADDR_SEC_RATE)) begin
      sec_rate <= pwdata;
    end
  end

  // Read back the rate; unmapped addresses return zero
  assign prdata = (paddr == CFG_ADDR_SEC_RATE) ? sec_rate : '0;

endmodule : rtcn_apb_regs
`default_nettype wire

// ===== rtl/rtcn_prescaler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTC prescaler
// Accumulates elapsed half-cycles and flags one second when the rate is
// reached; the surplus carries over, saturated at 32 bits.
// ----------------------------------------------------------------------------
module rtcn_prescaler (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        tick_en,
  input  wire logic [15:0] elapsed_cycles,
  input  wire logic [31:0] sec_rate,
  output logic             sec_pulse
);
  import rtcn_pkg::*;

  logic [31:0] prescaler;
  logic [31:0] prescaler_next;
  logic [32:0] sum;
  logic [32:0] surplus;

  // Add the tick and compare against the rate
  assign sum       = {1'b0, prescaler} + 33'(elapsed_cycles);
  assign sec_pulse = tick_en && (sum >= {1'b0, sec_rate});
  assign surplus   = sum - {1'b0, sec_rate};

  always_comb begin
    prescaler_next = prescaler;
    if (tick_en) begin
      if (sum < {1'b0, sec_rate}) begin
        prescaler_next = sum[31:0];
      end else if (surplus[32]) begin
        prescaler_next = '1;
      end else begin
        prescaler_next = surplus[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescaler <= '0;
    end else begin
      prescaler <= prescaler_next;
    end
  end

endmodule : rtcn_prescaler
`default_nettype wire

// ===== rtl/rtcn_calendar.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTC time, calendar and register file
// Holds the time of day as BCD digits plus a binary hour, the calendar, the
// control flags and the nibble RAM; decodes nibble register reads and writes.
// ----------------------------------------------------------------------------
module rtcn_calendar (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire rtcn_pkg::rtcn_item_t item,
  input  wire logic                sec_pulse,
  output logic [3:0]               read_nibble
);
  import rtcn_pkg::*;

  // Register addresses, bank 0
  localparam logic [3:0] R_SEC_U  = 4'd0;
  localparam logic [3:0] R_SEC_T  = 4'd1;
  localparam logic [3:0] R_MIN_U  = 4'd2;
  localparam logic [3:0] R_MIN_T  = 4'd3;
  localparam logic [3:0] R_HOUR_U = 4'd4;
  localparam logic [3:0] R_HOUR_T = 4'd5;
  localparam logic [3:0] R_WDAY   = 4'd6;
  localparam logic [3:0] R_DAY_U  = 4'd7;
  localparam logic [3:0] R_DAY_T  = 4'd8;
  localparam logic [3:0] R_MON_U  = 4'd9;
  localparam logic [3:0] R_MON_T  = 4'd10;
  localparam logic [3:0] R_YEAR_U = 4'd11;
  localparam logic [3:0] R_YEAR_T = 4'd12;
  // Bank 1
  localparam logic [3:0] R_H24    = 4'd10;
  localparam logic [3:0] R_LEAP   = 4'd11;
  // Common to all banks
  localparam logic [3:0] R_CTRL   = 4'd13;
  localparam logic [3:0] R_TEST   = 4'd14;
  localparam logic [3:0] R_OUT    = 4'd15;

  // Bank select codes
  localparam logic [1:0] MODE_TIME   = 2'd0;
  localparam logic [1:0] MODE_CTRL   = 2'd1;
  localparam logic [1:0] MODE_RAM_HI = 2'd3;

  typedef struct packed {
    logic [2:0] weekday;
    logic [5:0] day;
    logic [4:0] month;
    logic [6:0] year;
    logic [1:0] leap;
  } rtcn_cal_t;

  typedef struct packed {
    logic       off16;
    logic       off1;
    logic       h24;
    logic       timer;
    logic       alarm;
    logic [1:0] mode;
  } rtcn_flags_t;

  // Quotient by ten for values below 128
  function automatic logic [3:0] div10(input logic [6:0] v);
    logic [14:0] prod;
    prod = 15'(v) * 15'd205;
    return prod[14:11];
  endfunction

  function automatic logic [3:0] mod10(input logic [6:0] v);
    logic [6:0] rem;
    rem = v - 7'(div10(v)) * 7'd10;
    return rem[3:0];
  endfunction

  function automatic logic [3:0] nib_mod10(input logic [3:0] v);
    return (v >= 4'd10) ? v - 4'd10 : v;
  endfunction

  function automatic logic [2:0] nib_mod6(input logic [3:0] v);
    logic [3:0] r;
    if (v >= 4'd12) r = v - 4'd12;
    else if (v >= 4'd6) r = v - 4'd6;
    else r = v;
    return r[2:0];
  endfunction

  function automatic logic [2:0] nib_mod7(input logic [3:0] v);
    logic [3:0] r;
    if (v >= 4'd14) r = v - 4'd14;
    else if (v >= 4'd7) r = v - 4'd7;
    else r = v;
    return r[2:0];
  endfunction

  // Days in a month; month index counts from 0, out-of-range months get 31
  function automatic logic [5:0] month_len(input logic [4:0] m, input logic [1:0] leap);
    logic [5:0] len;
    case (m)
      5'd1: len = (leap == 2'd0) ? 6'd29 : 6'd28;
      5'd3, 5'd5, 5'd8, 5'd10: len = 6'd30;
      default: len = 6'd31;
    endcase
    return len;
  endfunction

  // Roll the calendar over by one day; folds at most four month lengths
  function automatic rtcn_cal_t advance_day(input rtcn_cal_t c);
    rtcn_cal_t  r;
    logic [5:0] len;
    logic       done;
    r       = c;
    done    = 1'b0;
    r.weekday = (c.weekday == 3'd6) ? 3'd0 : c.weekday + 3'd1;
    r.day     = c.day + 6'd1;
    for (int i = 0; i < 4; i++) begin
      len = month_len(r.month, r.leap);
      if (!done && (r.day >= len)) begin
        r.day = r.day - len;
        if (r.month >= 5'd11) begin
          r.month = '0;
          r.year  = (r.year == 7'd99) ? 7'd0 : r.year + 7'd1;
          r.leap  = r.leap + 2'd1;
        end else begin
          r.month = r.month + 5'd1;
        end
      end else begin
        done = 1'b1;
      end
    end
    return r;
  endfunction

  // State
  logic [3:0]  sec_u, sec_u_next;
  logic [2:0]  sec_t, sec_t_next;
  logic [3:0]  min_u, min_u_next;
  logic [2:0]  min_t, min_t_next;
  logic [4:0]  hour, hour_next;
  rtcn_cal_t   cal, cal_next;
  rtcn_flags_t flags, flags_next;
  logic [3:0]  ram [RAM_NIBBLES];

  // Decode helpers
  logic                 ram_sel;
  logic [RAM_IDX_W-1:0] ram_idx;
  logic                 ram_we;
  logic                 is_pm;
  logic [4:0]           hour12;
  logic [3:0]           hour12_t;
  logic [3:0]           hour_t;
  logic [5:0]           hour_wr;
  logic [3:0]           wv;

  assign wv       = item.write_nibble;
  assign ram_sel  = (item.reg_address < R_CTRL) && flags.mode[1];
  assign ram_idx  = RAM_IDX_W'(item.reg_address)
                  + ((flags.mode == MODE_RAM_HI) ? RAM_IDX_W'(RAM_BANK) : '0);
  assign is_pm    = (hour >= 5'd12);
  assign hour12   = is_pm ? hour - 5'd12 : hour;
  assign hour12_t = div10(7'(hour12));
  assign hour_t   = div10(7'(hour));

  // Hour value after a write to either hour digit, before the mod-24 fold
  always_comb begin
    if (flags.h24) begin
      if (item.reg_address == R_HOUR_U) begin
        hour_wr = 6'(hour_t) * 6'd10 + 6'(wv);
      end else begin
        hour_wr = 6'(mod10(7'(hour))) + 6'(wv[1:0]) * 6'd10;
      end
    end else begin
      if (item.reg_address == R_HOUR_U) begin
        hour_wr = 6'(hour12_t) * 6'd10 + 6'(wv) + (is_pm ? 6'd12 : 6'd0);
      end else begin
        hour_wr = 6'(mod10(7'(hour12))) + (wv[0] ? 6'd10 : 6'd0)
                + (wv[1] ? 6'd12 : 6'd0);
      end
    end
  end

  // Next state for a tick or a register write
  always_comb begin
    sec_u_next = sec_u;
    sec_t_next = sec_t;
    min_u_next = min_u;
    min_t_next = min_t;
    hour_next  = hour;
    cal_next   = cal;
    flags_next = flags;
    ram_we     = 1'b0;
    if (en && (item.op == OP_TICK) && sec_pulse) begin
      // Advance one second through the digit chain
      if (sec_u == 4'd9) begin
        sec_u_next = '0;
        if (sec_t == 3'd5) begin
          sec_t_next = '0;
          if (min_u == 4'd9) begin
            min_u_next = '0;
            if (min_t == 3'd5) begin
              min_t_next = '0;
              if (hour == 5'd23) begin
                hour_next = '0;
                cal_next  = advance_day(cal);
              end else begin
                hour_next = hour + 5'd1;
              end
            end else begin
              min_t_next = min_t + 3'd1;
            end
          end else begin
            min_u_next = min_u + 4'd1;
          end
        end else begin
          sec_t_next = sec_t + 3'd1;
        end
      end else begin
        sec_u_next = sec_u + 4'd1;
      end
    end else if (en && (item.op == OP_WRITE)) begin
      if (ram_sel) begin
        ram_we = 1'b1;
      end else if (item.reg_address == R_CTRL) begin
        {flags_next.timer, flags_next.alarm, flags_next.mode} = wv;
      end else if (item.reg_address == R_OUT) begin
        flags_next.off1  = wv[3];
        flags_next.off16 = wv[2];
      end else if (flags.mode == MODE_CTRL) begin
        if (item.reg_address == R_H24) begin
          flags_next.h24 = wv[0];
        end else if (item.reg_address == R_LEAP) begin
          cal_next.leap = wv[1:0];
        end
      end else if (flags.mode == MODE_TIME) begin
        case (item.reg_address)
          R_SEC_U:  sec_u_next = nib_mod10(wv);
          R_SEC_T:  sec_t_next = nib_mod6(wv);
          R_MIN_U:  min_u_next = nib_mod10(wv);
          R_MIN_T:  min_t_next = nib_mod6(wv);
          R_HOUR_U, R_HOUR_T: begin
            hour_next = (hour_wr >= 6'd24) ? 5'(hour_wr - 6'd24) : hour_wr[4:0];
          end
          R_WDAY:   cal_next.weekday = nib_mod7(wv);
          R_DAY_U:  cal_next.day = 6'(div10(7'(cal.day))) * 6'd10 + 6'(nib_mod10(wv));
          R_DAY_T:  cal_next.day = 6'(mod10(7'(cal.day))) + 6'(wv[1:0]) * 6'd10;
          R_MON_U:  cal_next.month = 5'(div10(7'(cal.month))) * 5'd10
                                   + 5'(nib_mod10(wv));
          R_MON_T:  cal_next.month = 5'(mod10(7'(cal.month))) + (wv[0] ? 5'd10 : 5'd0);
          R_YEAR_U: cal_next.year = 7'(div10(cal.year)) * 7'd10 + 7'(nib_mod10(wv));
          R_YEAR_T: cal_next.year = 7'(mod10(cal.year)) + 7'(nib_mod10(wv)) * 7'd10;
          default: ;
        endcase
      end
    end
  end

  // Read decode against the current state
  always_comb begin
    if (ram_sel) begin
      read_nibble = ram[ram_idx];
    end else if (item.reg_address == R_CTRL) begin
      read_nibble = {flags.timer, flags.alarm, flags.mode};
    end else if (item.reg_address == R_TEST) begin
      read_nibble = 4'hF;
    end else if (item.reg_address == R_OUT) begin
      read_nibble = {flags.off1, flags.off16, 2'b00};
    end else if (flags.mode == MODE_CTRL) begin
      if (item.reg_address == R_H24) begin
        read_nibble = {3'b000, flags.h24};
      end else if (item.reg_address == R_LEAP) begin
        read_nibble = {2'b00, cal.leap};
      end else begin
        read_nibble = 4'hF;
      end
    end else begin
      case (item.reg_address)
        R_SEC_U:  read_nibble = sec_u;
        R_SEC_T:  read_nibble = {1'b0, sec_t};
        R_MIN_U:  read_nibble = min_u;
        R_MIN_T:  read_nibble = {1'b0, min_t};
        R_HOUR_U: read_nibble = flags.h24 ? mod10(7'(hour)) : mod10(7'(hour12));
        R_HOUR_T: read_nibble = flags.h24 ? hour_t : hour12_t + (is_pm ? 4'd2 : 4'd0);
        R_WDAY:   read_nibble = {1'b0, cal.weekday};
        R_DAY_U:  read_nibble = mod10(7'(cal.day));
        R_DAY_T:  read_nibble = div10(7'(cal.day));
        R_MON_U:  read_nibble = mod10(7'(cal.month));
        R_MON_T:  read_nibble = div10(7'(cal.month));
        R_YEAR_U: read_nibble = mod10(cal.year);
        default:  read_nibble = div10(cal.year);
      endcase
    end
  end

  // Time, calendar and flag registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sec_u <= '0;
      sec_t <= '0;
      min_u <= '0;
      min_t <= '0;
      hour  <= '0;
      cal   <= '0;
      flags <= '0;
    end else begin
      sec_u <= sec_u_next;
      sec_t <= sec_t_next;
      min_u <= min_u_next;
      min_t <= min_t_next;
      hour  <= hour_next;
      cal   <= cal_next;
      flags <= flags_next;
    end
  end

  // Nibble RAM, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RAM_NIBBLES; i++) begin
        ram[i] <= '0;
      end
    end else if (ram_we) begin
      ram[ram_idx] <= wv;
    end
  end

endmodule : rtcn_calendar
`default_nettype wire

// ===== rtl/rtc_nibble_register_clock_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RTC nibble register clock unit
// Real-time clock and calendar behind sixteen 4-bit registers in four banks,
// driven by tick words that carry elapsed half-cycles.
// ----------------------------------------------------------------------------
// The unit takes one word per clock cycle while in_stall is low and returns one
// result word per input word: the word is captured in an input register, the
// state update and register read happen as it moves on, and the result lands
// in an output register. The state update (prescaler add/compare, second and
// day rollover, nibble register decode) is combinational between the two
// registers. A result waiting on a stalled output does not block the next
// input word; the input stalls only when both the input and output registers
// are full. Reads return 0xF0 with the register nibble in the low four bits;
// ticks and writes return 0. The user must write the prescaler rate through the
// APB port at address 0 only while the unit is idle; the block does not enforce
// it. The nibble RAM is cleared by reset with no extra initialization time.
// ----------------------------------------------------------------------------
module rtc_nibble_register_clock_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Input word channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   op,
  input  wire logic [3:0]                   reg_address,
  input  wire logic [3:0]                   write_nibble,
  input  wire logic [15:0]                  elapsed_cycles,
  // Result word channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [7:0]                   read_data,
  // Configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rtcn_pkg::PADDR_W-1:0] paddr,
  input  wire logic [rtcn_pkg::PDATA_W-1:0] pwdata,
  output logic      [rtcn_pkg::PDATA_W-1:0] prdata,
  output logic                              pready
);
  import rtcn_pkg::*;

  rtcn_item_t  item;
  logic        item_valid;
  logic        advance;
  logic        in_take;
  logic [31:0] sec_rate;
  logic        sec_pulse;
  logic [3:0]  read_nibble;

  // Move the held word forward when the output register is free or draining
  assign advance  = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.op             <= op;
      item.reg_address    <= reg_address;
      item.write_nibble   <= write_nibble;
      item.elapsed_cycles <= elapsed_cycles;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data <= (item.op == OP_READ) ? {READ_MARK, read_nibble} : 8'h00;
    end
  end

  rtcn_apb_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .sec_rate (sec_rate)
  );

  rtcn_prescaler u_prescaler (
    .clk            (clk),
    .rst            (rst),
    .tick_en        (advance && (item.op == OP_TICK)),
    .elapsed_cycles (item.elapsed_cycles),
    .sec_rate       (sec_rate),
    .sec_pulse      (sec_pulse)
  );

  rtcn_calendar u_calendar (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .item        (item),
    .sec_pulse   (sec_pulse),
    .read_nibble (read_nibble)
  );

endmodule : rtc_nibble_register_clock_unit
`default_nettype wire

// ===== test/rtcn_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC nibble register clock: result checker
// Shared testbench names, then a passive checker that snoops the word
// channels and the APB port, keeps its own copy of the clock and calendar
// state, predicts the read_data of every accepted word and compares it with
// the returned words in order.
// ----------------------------------------------------------------------------
package rtcn_tb_pkg;

  // Opcode the block must ignore
  localparam logic [1:0] OP_IDLE = 2'd3;

  // Register bank select (control register bits 1..0)
  localparam logic [1:0] MODE_TIME     = 2'd0;
  localparam logic [1:0] MODE_SETUP    = 2'd1;
  localparam logic [1:0] MODE_RAM_LOW  = 2'd2;
  localparam logic [1:0] MODE_RAM_HIGH = 2'd3;

  // Nibble register addresses, time bank
  localparam logic [3:0] REG_SEC_UNITS   = 4'd0;
  localparam logic [3:0] REG_SEC_TENS    = 4'd1;
  localparam logic [3:0] REG_MIN_UNITS   = 4'd2;
  localparam logic [3:0] REG_MIN_TENS    = 4'd3;
  localparam logic [3:0] REG_HOUR_UNITS  = 4'd4;
  localparam logic [3:0] REG_HOUR_TENS   = 4'd5;
  localparam logic [3:0] REG_WEEKDAY     = 4'd6;
  localparam logic [3:0] REG_DAY_UNITS   = 4'd7;
  localparam logic [3:0] REG_DAY_TENS    = 4'd8;
  localparam logic [3:0] REG_MONTH_UNITS = 4'd9;
  localparam logic [3:0] REG_MONTH_TENS  = 4'd10;
  localparam logic [3:0] REG_YEAR_UNITS  = 4'd11;
  localparam logic [3:0] REG_YEAR_TENS   = 4'd12;
  // Setup bank
  localparam logic [3:0] REG_HOUR_MODE   = 4'd10;
  localparam logic [3:0] REG_LEAP        = 4'd11;
  // Common to every bank
  localparam logic [3:0] REG_CONTROL     = 4'd13;
  localparam logic [3:0] REG_TEST        = 4'd14;
  localparam logic [3:0] REG_OUTPUT      = 4'd15;

  // Rate extremes
  localparam logic [31:0] RATE_MIN = 32'd65536;
  localparam logic [31:0] RATE_MAX = 32'hFFFF_FFFF;

endpackage : rtcn_tb_pkg

module rtcn_checker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic                         in_stall,
  input  wire logic [1:0]                   op,
  input  wire logic [3:0]                   reg_address,
  input  wire logic [3:0]                   write_nibble,
  input  wire logic [15:0]                  elapsed_cycles,
  input  wire logic                         out_valid,
  input  wire logic                         out_stall,
  input  wire logic [7:0]                   read_data,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rtcn_pkg::PADDR_W-1:0] paddr,
  input  wire logic [rtcn_pkg::PDATA_W-1:0] pwdata,
  input  wire logic [rtcn_pkg::PDATA_W-1:0] prdata,
  input  wire logic                         pready,
  output int unsigned                       fail_count,
  output int unsigned                       pending,
  output int unsigned                       words_checked,
  output int unsigned                       reads_checked,
  output int unsigned                       seconds_rolled,
  output int unsigned                       days_rolled
);
  import rtcn_pkg::*;
  import rtcn_tb_pkg::*;

  localparam int unsigned DAY_SECONDS  = 86400;
  localparam int unsigned HOUR_SECONDS = 3600;
  localparam int unsigned REPORT_LIMIT = 10;
  // Control flag bits above the bank select
  localparam int unsigned H24_BIT      = 4;
  localparam int unsigned OFF_1HZ_BIT  = 5;
  localparam int unsigned OFF_16HZ_BIT = 6;

  // Mirror of the clock state
  logic [31:0] rate;
  logic [31:0] prescale;
  int unsigned sod;
  int unsigned wday;
  int unsigned day_i;
  int unsigned mon_i;
  int unsigned year_i;
  int unsigned leap;
  logic [6:0]  flags;
  logic [3:0]  ram [RAM_NIBBLES];

  // read_data words still owed by the block, oldest first
  logic [7:0]  due_read_data [$];

  function automatic int unsigned month_days(int unsigned m);
    if (m == 1) return (leap == 0) ? 29 : 28;
    if (m == 3 || m == 5 || m == 8 || m == 10) return 30;
    return 31;
  endfunction

  // Step to the next day; a day past the month length keeps rolling months
  function automatic void roll_day();
    int unsigned len;
    wday = (wday + 1) % 7;
    day_i++;
    for (int g = 0; g < 4; g++) begin
      len = month_days(mon_i);
      if (day_i < len) break;
      day_i -= len;
      if (mon_i >= 11) begin
        mon_i = 0;
        year_i = (year_i + 1) % 100;
        leap = (leap + 1) & 3;
      end else begin
        mon_i++;
      end
    end
  endfunction

  function automatic void apply_tick(logic [15:0] cycles);
    logic [32:0] total;
    total = {1'b0, prescale} + cycles;
    if (total < {1'b0, rate}) begin
      prescale = total[31:0];
      return;
    end
    // one second passes, surplus carries, saturated at 32 bits
    total = total - {1'b0, rate};
    prescale = total[32] ? 32'hFFFF_FFFF : total[31:0];
    sod++;
    seconds_rolled++;
    if (sod >= DAY_SECONDS) begin
      sod -= DAY_SECONDS;
      roll_day();
      days_rolled++;
    end
  endfunction

  function automatic void set_hours(logic [3:0] addr, int unsigned v);
    int unsigned h;
    int unsigned rest;
    int unsigned pm;
    int unsigned h12;
    h = sod / HOUR_SECONDS;
    rest = sod % HOUR_SECONDS;
    if (flags[H24_BIT]) begin
      if (addr == REG_HOUR_UNITS) h = h - (h % 10) + v;
      else h = (h % 10) + (v & 3) * 10;
    end else begin
      // 12-hour tens: bit 0 is the tens digit, bit 1 is PM
      pm = (h >= 12) ? 1 : 0;
      h12 = h % 12;
      if (addr == REG_HOUR_UNITS) begin
        h12 = h12 - (h12 % 10) + v;
      end else begin
        h12 = (h12 % 10) + (v & 1) * 10;
        pm = (v >> 1) & 1;
      end
      h = h12 + pm * 12;
    end
    sod = (h % 24) * HOUR_SECONDS + rest;
  endfunction

  function automatic void set_time_digit(logic [3:0] addr, int unsigned v);
    int unsigned hr;
    int unsigned su;
    int unsigned st;
    int unsigned mu;
    int unsigned mt;
    hr = sod / HOUR_SECONDS;
    su = (sod % 60) % 10;
    st = (sod % 60) / 10;
    mu = ((sod / 60) % 60) % 10;
    mt = ((sod / 60) % 60) / 10;
    case (addr)
      REG_SEC_UNITS: su = v % 10;
      REG_SEC_TENS:  st = v % 6;
      REG_MIN_UNITS: mu = v % 10;
      default:       mt = v % 6;
    endcase
    sod = hr * HOUR_SECONDS + (mt * 10 + mu) * 60 + st * 10 + su;
  endfunction

  function automatic int unsigned ram_slot(logic [3:0] addr, logic [1:0] mode);
    return (addr + ((mode == MODE_RAM_HIGH) ? RAM_BANK : 0)) % RAM_NIBBLES;
  endfunction

  function automatic void apply_write(logic [3:0] addr, logic [3:0] v);
    logic [1:0] mode;
    mode = flags[1:0];
    if (addr < REG_CONTROL && mode >= MODE_RAM_LOW) begin
      ram[ram_slot(addr, mode)] = v;
      return;
    end
    if (addr == REG_CONTROL) begin
      flags[3:0] = v;
      return;
    end
    if (addr == REG_OUTPUT) begin
      flags[OFF_1HZ_BIT] = v[3];
      flags[OFF_16HZ_BIT] = v[2];
      return;
    end
    if (mode == MODE_SETUP) begin
      if (addr == REG_HOUR_MODE) flags[H24_BIT] = v[0];
      else if (addr == REG_LEAP) leap = v & 3;
      return;
    end
    // time bank; the test register falls through untouched
    case (addr)
      REG_SEC_UNITS, REG_SEC_TENS, REG_MIN_UNITS, REG_MIN_TENS: set_time_digit(addr, v);
      REG_HOUR_UNITS, REG_HOUR_TENS: set_hours(addr, v);
      REG_WEEKDAY:     wday = v % 7;
      REG_DAY_UNITS:   day_i = (day_i / 10) * 10 + v % 10;
      REG_DAY_TENS:    day_i = day_i % 10 + (v & 3) * 10;
      REG_MONTH_UNITS: mon_i = (mon_i / 10) * 10 + v % 10;
      REG_MONTH_TENS:  mon_i = mon_i % 10 + (v & 1) * 10;
      REG_YEAR_UNITS:  year_i = (year_i / 10) * 10 + v % 10;
      REG_YEAR_TENS:   year_i = year_i % 10 + (v % 10) * 10;
      default: ;
    endcase
  endfunction

  function automatic logic [3:0] peek_register(logic [3:0] addr);
    logic [1:0]  mode;
    int unsigned h;
    logic        h24;
    mode = flags[1:0];
    h = sod / HOUR_SECONDS;
    h24 = flags[H24_BIT];
    if (addr < REG_CONTROL && mode >= MODE_RAM_LOW) return ram[ram_slot(addr, mode)];
    if (addr == REG_CONTROL) return flags[3:0];
    if (addr == REG_TEST) return 4'hF;
    if (addr == REG_OUTPUT) return {flags[OFF_1HZ_BIT], flags[OFF_16HZ_BIT], 2'b00};
    if (mode == MODE_SETUP) begin
      if (addr == REG_HOUR_MODE) return {3'b000, h24};
      if (addr == REG_LEAP) return 4'(leap);
      return 4'hF;
    end
    case (addr)
      REG_SEC_UNITS:   return 4'(sod % 10);
      REG_SEC_TENS:    return 4'((sod / 10) % 6);
      REG_MIN_UNITS:   return 4'((sod / 60) % 10);
      REG_MIN_TENS:    return 4'((sod / 600) % 6);
      REG_HOUR_UNITS:  return 4'(h24 ? h % 10 : (h % 12) % 10);
      REG_HOUR_TENS:   return 4'(h24 ? h / 10 : (h % 12) / 10 + ((h >= 12) ? 2 : 0));
      REG_WEEKDAY:     return 4'(wday);
      REG_DAY_UNITS:   return 4'(day_i % 10);
      REG_DAY_TENS:    return 4'(day_i / 10);
      REG_MONTH_UNITS: return 4'(mon_i % 10);
      REG_MONTH_TENS:  return 4'(mon_i / 10);
      REG_YEAR_UNITS:  return 4'(year_i % 10);
      default:         return 4'(year_i / 10);
    endcase
  endfunction

  // Advance the mirror by one word and return the read_data it owes
  function automatic logic [7:0] predict_read_data(logic [1:0] kind, logic [3:0] addr,
                                                   logic [3:0] v, logic [15:0] cycles);
    logic [7:0] word;
    word = 8'h00;
    case (kind)
      OP_TICK:  apply_tick(cycles);
      OP_READ:  word = {READ_MARK, peek_register(addr)};
      OP_WRITE: apply_write(addr, v);
      default: ;
    endcase
    return word;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("rtcn_checker: %s", msg);
  endtask

  always @(posedge clk) begin : watch
    logic [7:0] want;
    if (rst) begin
      rate = SEC_RATE_RESET;
      prescale = '0;
      sod = 0;
      wday = 0;
      day_i = 0;
      mon_i = 0;
      year_i = 0;
      leap = 0;
      flags = '0;
      for (int i = 0; i < RAM_NIBBLES; i++) ram[i] = 4'h0;
      due_read_data.delete();
      fail_count = 0;
      words_checked = 0;
      reads_checked = 0;
      seconds_rolled = 0;
      days_rolled = 0;
    end else begin
      // track rate writes, check reads of it
      if (psel && penable && pready && paddr == CFG_ADDR_SEC_RATE) begin
        if (pwrite) begin
          rate = pwdata;
        end else if (prdata != rate) begin
          note_failure($sformatf("rate read: expected %0d, got %0d", rate, prdata));
        end
      end
      // compare a returned word with the oldest expectation
      if (out_valid && !out_stall) begin
        words_checked++;
        if (due_read_data.size() == 0) begin
          note_failure($sformatf("result word 0x%02h with nothing expected", read_data));
        end else begin
          want = due_read_data.pop_front();
          if (want[7:4] == READ_MARK) reads_checked++;
          if (read_data != want)
            note_failure($sformatf("read_data: expected 0x%02h, got 0x%02h", want, read_data));
        end
      end
      // predict for a newly accepted word
      if (in_valid && !in_stall)
        due_read_data.push_back(predict_read_data(op, reg_address, write_nibble,
                                                  elapsed_cycles));
    end
    pending <= due_read_data.size();
  end

endmodule : rtcn_checker

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC nibble register clock: testbench top
// Drives tick, read and write words into the clock unit with random gaps and
// result stalls, steps the second rate through its extremes over the APB port
// between phases, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
  import rtcn_pkg::*;
  import rtcn_tb_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned LONG_HOLD    = 60;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  wire logic            in_stall;
  logic [1:0]           op;
  logic [3:0]           reg_address;
  logic [3:0]           write_nibble;
  logic [15:0]          elapsed_cycles;
  wire logic            out_valid;
  logic                 out_stall;
  wire logic [7:0]      read_data;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  wire logic [PDATA_W-1:0] prdata;
  wire logic            pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_checked;
  int unsigned reads_checked;
  int unsigned seconds_rolled;
  int unsigned days_rolled;

  int unsigned words_sent;
  int unsigned settings_used;
  bit          steady;

  rtc_nibble_register_clock_unit uut (.*);

  rtcn_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [3:0] rnd4();
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [15:0] rnd16();
    return 16'($urandom_range(0, 65535));
  endfunction

  // Mostly near-full ticks so seconds actually roll at the low rates
  function automatic logic [15:0] big_elapsed();
    if ($urandom_range(0, 3) == 0) return rnd16();
    return 16'($urandom_range(60000, 65535));
  endfunction

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(input logic [1:0] kind, input logic [3:0] addr,
                           input logic [3:0] v, input logic [15:0] cycles);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= kind;
    reg_address <= addr;
    write_nibble <= v;
    elapsed_cycles <= cycles;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [3:0] v);
    send_word(OP_WRITE, addr, v, rnd16());
  endtask

  task automatic read_reg(input logic [3:0] addr);
    send_word(OP_READ, addr, rnd4(), rnd16());
  endtask

  task automatic tick_word(input logic [15:0] cycles);
    send_word(OP_TICK, rnd4(), rnd4(), cycles);
  endtask

  // Select a bank, with random alarm and timer enable bits
  task automatic set_mode(input logic [1:0] mode);
    write_reg(REG_CONTROL, {2'($urandom_range(0, 3)), mode});
  endtask

  // Drop valid and wait until every owed word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, access cycle, then release
  task automatic apb_access(input logic wr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= CFG_ADDR_SEC_RATE;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_rate(input logic [31:0] value);
    wait_drained();
    repeat (2) @(posedge clk);
    apb_access(1'b1, value);
    apb_access(1'b0, 32'h0);
    settings_used++;
  endtask

  // Random traffic: calendar set-up with ticks and reads, RAM banks, hour digits, any opcode, tick runs
  task automatic run_phase(input int unsigned quota);
    int unsigned stop_at;
    int unsigned day;
    int unsigned month;
    logic [3:0]  hv;
    bit          near;
    stop_at = words_sent + quota;
    while (words_sent < stop_at) begin
      steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // set the time near a rollover, then tick across it
          near = ($urandom_range(0, 3) != 0);
          hv = rnd4();
          set_mode(MODE_SETUP);
          write_reg(REG_HOUR_MODE, hv);
          write_reg(REG_LEAP, rnd4());
          set_mode(MODE_TIME);
          write_reg(REG_SEC_UNITS, near ? 4'd9 : rnd4());
          write_reg(REG_SEC_TENS, near ? 4'd5 : rnd4());
          write_reg(REG_MIN_UNITS, near ? 4'd9 : rnd4());
          write_reg(REG_MIN_TENS, near ? 4'd5 : rnd4());
          write_reg(REG_HOUR_UNITS, near ? (hv[0] ? 4'd3 : 4'd1) : rnd4());
          write_reg(REG_HOUR_TENS, near ? {2'($urandom_range(0, 3)), hv[0] ? 2'd2 : 2'd3}
                                        : rnd4());
          day = near ? (($urandom_range(0, 3) == 0) ? 39 : $urandom_range(27, 31))
                     : $urandom_range(0, 39);
          month = near ? (($urandom_range(0, 2) == 0) ? $urandom_range(12, 19)
                                                       : (($urandom_range(0, 1) == 0) ? 1 : 11))
                       : $urandom_range(0, 19);
          write_reg(REG_DAY_UNITS, 4'(day % 10));
          write_reg(REG_DAY_TENS, {2'($urandom_range(0, 3)), 2'(day / 10)});
          write_reg(REG_MONTH_UNITS, 4'(month % 10));
          write_reg(REG_MONTH_TENS, {3'($urandom_range(0, 7)), 1'(month / 10)});
          write_reg(REG_WEEKDAY, rnd4());
          write_reg(REG_YEAR_UNITS, near ? 4'd9 : rnd4());
          write_reg(REG_YEAR_TENS, near ? 4'd9 : rnd4());
          repeat ($urandom_range(2, 8)) tick_word(big_elapsed());
          repeat ($urandom_range(4, 13)) read_reg(4'($urandom_range(0, 12)));
        end
        4, 5: begin
          // RAM banks
          set_mode(2'($urandom_range(2, 3)));
          repeat ($urandom_range(4, 12)) begin
            if ($urandom_range(0, 1) == 0) write_reg(rnd4(), rnd4());
            else read_reg(rnd4());
            if ($urandom_range(0, 5) == 0) set_mode(2'($urandom_range(2, 3)));
          end
        end
        6: begin
          // hour digits in both formats
          set_mode(MODE_SETUP);
          write_reg(REG_HOUR_MODE, rnd4());
          set_mode(MODE_TIME);
          repeat (4) begin
            write_reg(($urandom_range(0, 1) == 0) ? REG_HOUR_UNITS : REG_HOUR_TENS, rnd4());
            read_reg(REG_HOUR_UNITS);
            read_reg(REG_HOUR_TENS);
          end
        end
        7: begin
          // anything goes, unknown opcode included
          repeat ($urandom_range(2, 6)) send_word(2'($urandom_range(0, 3)), rnd4(), rnd4(),
                                                  rnd16());
        end
        default: begin
          repeat ($urandom_range(8, 30)) begin
            if ($urandom_range(0, 5) == 0) read_reg(rnd4());
            else tick_word(($urandom_range(0, 1) == 0) ? 16'hFFFF : rnd16());
          end
        end
      endcase
    end
  endtask

  // Result side: random stalls, calm stretches, and a long hold-off every 700 results
  initial begin : result_sink
    int unsigned taken;
    int unsigned hold;
    bit          calm;
    out_stall <= 1'b0;
    taken = 0;
    calm = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken % 50 == 0) calm = ($urandom_range(0, 2) == 0);
      if (taken % 700 == 200) hold = LONG_HOLD;
      else hold = calm ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // Give up when nothing moves for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    op <= OP_TICK;
    reg_address <= '0;
    write_nibble <= '0;
    elapsed_cycles <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= CFG_ADDR_SEC_RATE;
    pwdata <= '0;
    words_sent = 0;
    settings_used = 1;
    steady = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset value of the rate
    apb_access(1'b0, 32'h0);

    // directed: shared registers, unknown op, tick extremes
    read_reg(REG_CONTROL);
    read_reg(REG_TEST);
    read_reg(REG_OUTPUT);
    send_word(OP_IDLE, 4'hF, 4'hF, 16'hFFFF);
    tick_word(16'h0000);
    tick_word(16'hFFFF);
    read_reg(REG_HOUR_TENS);
    write_reg(REG_OUTPUT, 4'hC);
    read_reg(REG_OUTPUT);
    // test register ignores writes
    write_reg(REG_TEST, 4'hF);
    read_reg(REG_TEST);
    // setup bank: 24-hour flag, leap counter, empty slot
    write_reg(REG_CONTROL, {2'b11, MODE_SETUP});
    write_reg(REG_HOUR_MODE, 4'hF);
    write_reg(REG_LEAP, 4'hF);
    read_reg(REG_LEAP);
    read_reg(REG_HOUR_MODE);
    read_reg(REG_SEC_UNITS);
    // hour tens past 23 wrap
    write_reg(REG_CONTROL, {2'b00, MODE_TIME});
    write_reg(REG_HOUR_TENS, 4'hF);
    read_reg(REG_HOUR_TENS);
    // last RAM nibble through the high bank, then the low bank view
    write_reg(REG_CONTROL, {2'b01, MODE_RAM_HIGH});
    write_reg(REG_YEAR_TENS, 4'hA);
    read_reg(REG_YEAR_TENS);
    write_reg(REG_CONTROL, {2'b10, MODE_RAM_LOW});
    read_reg(REG_YEAR_TENS);

    run_phase(250);
    set_rate(RATE_MIN);
    run_phase(300);
    // the prescaler piles up at the top rate ...
    set_rate(RATE_MAX);
    run_phase(300);
    // ... and the surplus makes every tick a second here
    set_rate(RATE_MIN);
    run_phase(300);
    set_rate(32'($urandom_range(65536, 1000000)));
    run_phase(250);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb_top: %0d words sent, %0d results checked (%0d reads)",
             words_sent, words_checked, reads_checked);
    $display("tb_top: %0d rate settings, %0d seconds and %0d days rolled",
             settings_used, seconds_rolled, days_rolled);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule : tb_top

// ===== filelist.f =====
rtl/rtcn_pkg.sv
rtl/rtcn_apb_regs.sv
rtl/rtcn_prescaler.sv
rtl/rtcn_calendar.sv
rtl/rtc_nibble_register_clock_unit.sv
test/rtcn_checker.sv
test/tb_top.sv
